[src/u8u16_pkg.sv]
package u8u16_pkg;

   // accumulator width: a legal sequence has at most four bytes, 8 + 3*6 bits
   localparam int ACC_W = 26;

   localparam logic [7:0] TRAIL_LO = 8'h80;
   localparam logic [7:0] TRAIL_HI = 8'hBF;
   localparam logic [7:0] LEAD_MIN = 8'hC2;
   localparam logic [7:0] LEAD_MAX = 8'hF4;
   localparam logic [7:0] LEAD_E0 = 8'hE0;
   localparam logic [7:0] LEAD_F0 = 8'hF0;
   localparam logic [7:0] LEAD_F4 = 8'hF4;
   localparam logic [7:0] E0_TRAIL_MIN = 8'hA0;
   localparam logic [7:0] F0_TRAIL_MIN = 8'h90;
   localparam logic [7:0] F4_TRAIL_MAX = 8'h8F;

   localparam logic [ACC_W-1:0] BMP_MAX = ACC_W'(32'h0000_FFFF);
   localparam logic [ACC_W-1:0] CP_MAX = ACC_W'(32'h0010_FFFF);
   localparam logic [ACC_W-1:0] SUPP_BASE = ACC_W'(32'h0001_0000);
   localparam logic [ACC_W-1:0] SURR_MIN = ACC_W'(32'h0000_D800);
   localparam logic [ACC_W-1:0] SURR_MAX = ACC_W'(32'h0000_DFFF);
   localparam logic [15:0] HI_SURR_BASE = 16'hD800;
   localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

   localparam int MAX_RESULTS = 3;

   typedef enum logic [1:0] {
      STAT_UNIT    = 2'd0,
      STAT_DONE    = 2'd1,
      STAT_PARTIAL = 2'd2,
      STAT_ILLEGAL = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_stream;
   } req_word_type;

   typedef struct packed {
      logic [15:0] code_unit;
      status_type  status;
      logic        last;
   } rsp_word_type;

   // results of one accepted byte, handed from the decoder to the output queue
   typedef struct packed {
      logic [1:0]                       num;
      rsp_word_type [MAX_RESULTS-1:0]   word;
   } dec_out_type;

   // number of trailing bytes announced by a lead byte
   function automatic logic [2:0] trail_count(input logic [7:0] b);
      logic [2:0] n;
      case (b) inside
         [8'h00:8'hBF]: n = 3'd0;
         [8'hC0:8'hDF]: n = 3'd1;
         [8'hE0:8'hEF]: n = 3'd2;
         [8'hF0:8'hF7]: n = 3'd3;
         [8'hF8:8'hFB]: n = 3'd4;
         default:       n = 3'd5;
      endcase
      return n;
   endfunction

   // marker bits removed from the shifted byte sum, per trail count
   function automatic logic [ACC_W-1:0] seq_offset(input logic [2:0] n);
      logic [ACC_W-1:0] r;
      case (n)
         3'd0:    r = ACC_W'(32'h0000_0000);
         3'd1:    r = ACC_W'(32'h0000_3080);
         3'd2:    r = ACC_W'(32'h000E_2080);
         3'd3:    r = ACC_W'(32'h03C8_2080);
         3'd4:    r = ACC_W'(32'hFA08_2080);
         3'd5:    r = ACC_W'(32'h8208_2080);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[src/utf8_to_utf16_decoder_unit.sv]
// channel   direction  handshake           word
// req_      in         req_valid/req_stall req_word_type: byte_in, end_of_stream
// rsp_      out        rsp_valid/rsp_stall rsp_word_type: code_unit, status, last
// csr_      in         csr_valid/csr_ready strict_mode, 1 bit
//
// one byte is taken per cycle unless req_stall; its zero to three result words leave
// one per cycle unless rsp_stall, from a three-entry output queue.
// the decoder state and the byte's results are settled in the cycle of acceptance.
// synchronous reset clears the sequence state, the queue and sets strict_mode.
// req_stall rises while the queue holds more than the word leaving this cycle.
// after an illegal sequence or end of stream, bytes are taken and dropped until reset.
module utf8_to_utf16_decoder_unit
   import u8u16_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data
);

   logic                           strict_ff;
   rsp_word_type [MAX_RESULTS-1:0] q_ff, q_in;
   logic [1:0]                     cnt_ff, cnt_in;
   logic                           accept;
   logic                           take;
   dec_out_type                    dec;

   // handshakes
   assign take      = rsp_valid && !rsp_stall;
   assign req_stall = !((cnt_ff == 2'd0) || (cnt_ff == 2'd1 && !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   u8u16_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .strict (strict_ff),
      .word   (req_data),
      .dec    (dec)
   );

   // output queue: shift out at the head, load when it drains
   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (take) begin
         q_in[0] = q_ff[1];
         q_in[1] = q_ff[2];
         cnt_in  = cnt_ff - 2'd1;
      end
      if (accept) begin
         q_in   = dec.word;
         cnt_in = dec.num;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   // strict mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         strict_ff <= csr_data;
      end
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = q_ff[0];

endmodule

[src/u8u16_decode.sv]
module u8u16_decode
   import u8u16_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic         strict,
   input  req_word_type word,
   output dec_out_type  dec
);

   logic [7:0]       lead_ff, lead_in;
   logic [2:0]       needed_ff, needed_in;
   logic [2:0]       seen_ff, seen_in;
   logic [7:0]       first_ff, first_in;
   logic             bad_ff, bad_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             halted_ff, halted_in;

   logic [2:0]       needed;
   logic             done;
   logic             legal;
   logic             illegal;
   logic [ACC_W-1:0] ch;
   logic [ACC_W-1:0] supp;
   logic [1:0]       unit_n;
   logic [15:0]      unit0, unit1;
   logic [1:0]       idx;

   // sequence gathering: lead byte opens, trail bytes shift in
   always_comb begin
      lead_in   = lead_ff;
      needed_in = needed_ff;
      seen_in   = seen_ff;
      first_in  = first_ff;
      bad_in    = bad_ff;
      acc_in    = acc_ff;
      needed    = needed_ff;
      done      = 1'b0;
      if (needed_ff == 3'd0) begin
         lead_in  = word.byte_in;
         needed   = trail_count(word.byte_in);
         seen_in  = 3'd0;
         first_in = 8'd0;
         bad_in   = 1'b0;
         acc_in   = ACC_W'(word.byte_in);
         done     = (needed == 3'd0);
         needed_in = needed;
      end else begin
         acc_in = {acc_ff[ACC_W-7:0], 6'b0} + ACC_W'(word.byte_in);
         if (seen_ff == 3'd0) begin
            first_in = word.byte_in;
         end else if (word.byte_in < TRAIL_LO || word.byte_in > TRAIL_HI) begin
            bad_in = 1'b1;
         end
         seen_in = seen_ff + 3'd1;
         done    = (seen_in >= needed);
      end
      if (done) begin
         needed_in = 3'd0;
         seen_in   = 3'd0;
      end
   end

   // legality of the completed sequence
   always_comb begin
      legal = 1'b1;
      if (needed > 3'd3) begin
         legal = 1'b0;
      end
      if (needed >= 3'd1) begin
         if (first_in < TRAIL_LO || first_in > TRAIL_HI) legal = 1'b0;
         if (bad_in) legal = 1'b0;
         if (lead_in == LEAD_E0 && first_in < E0_TRAIL_MIN) legal = 1'b0;
         if (lead_in == LEAD_F0 && first_in < F0_TRAIL_MIN) legal = 1'b0;
         if (lead_in == LEAD_F4 && first_in > F4_TRAIL_MAX) legal = 1'b0;
      end
      if (lead_in >= TRAIL_LO && lead_in < LEAD_MIN) legal = 1'b0;
      if (lead_in > LEAD_MAX) legal = 1'b0;
   end

   // code point and its utf-16 units
   assign ch   = acc_in - seq_offset(needed);
   assign supp = ch - SUPP_BASE;

   always_comb begin
      illegal = 1'b0;
      unit_n  = 2'd0;
      unit0   = 16'd0;
      unit1   = 16'd0;
      if (done) begin
         if (!legal) begin
            illegal = 1'b1;
         end else if (ch <= BMP_MAX) begin
            if (strict && ch >= SURR_MIN && ch <= SURR_MAX) begin
               illegal = 1'b1;
            end else begin
               unit_n = 2'd1;
               unit0  = ch[15:0];
            end
         end else if (ch > CP_MAX) begin
            illegal = 1'b1;
         end else begin
            unit_n = 2'd2;
            unit0  = HI_SURR_BASE + {6'd0, supp[19:10]};
            unit1  = LO_SURR_BASE + {6'd0, supp[9:0]};
         end
      end
   end

   // result words for this byte, last flag on the final one
   always_comb begin
      dec     = '0;
      idx     = unit_n;
      if (illegal) begin
         dec.num            = 2'd1;
         dec.word[0].status = STAT_ILLEGAL;
      end else begin
         dec.word[0].code_unit = unit0;
         dec.word[1].code_unit = unit1;
         dec.num = unit_n;
         if (word.end_of_stream) begin
            dec.word[idx].code_unit = 16'd0;
            dec.word[idx].status    = done ? STAT_DONE : STAT_PARTIAL;
            dec.num                 = unit_n + 2'd1;
         end
      end
      if (halted_ff) begin
         dec.num = 2'd0;
      end
      for (int i = 0; i < MAX_RESULTS; i++) begin
         dec.word[i].last = (dec.num != 2'd0) && (2'(i) == dec.num - 2'd1);
      end
   end

   assign halted_in = halted_ff | (accept & (illegal | word.end_of_stream));

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff   <= '0;
         needed_ff <= '0;
         seen_ff   <= '0;
         first_ff  <= '0;
         bad_ff    <= 1'b0;
         acc_ff    <= '0;
         halted_ff <= 1'b0;
      end else if (accept && !halted_ff) begin
         lead_ff   <= lead_in;
         needed_ff <= needed_in;
         seen_ff   <= seen_in;
         first_ff  <= first_in;
         bad_ff    <= bad_in;
         acc_ff    <= acc_in;
         halted_ff <= halted_in;
      end
   end

endmodule

[src/u8u16_checker.sv]
module u8u16_checker
   import u8u16_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // a status word closes the words of its byte
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STAT_UNIT |-> rsp_data.last)
      else $error("status word without last");

   // after a status word is taken nothing more comes out
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.status != STAT_UNIT |=> !rsp_valid)
      else $error("result after halt");

   // the words of one byte leave back to back
   a_group_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid)
      else $error("word group broken");

   // input is only held off while results are pending
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty queue");

endmodule

bind utf8_to_utf16_decoder_unit u8u16_checker u_checker (.*);

[verif/utf8_to_utf16_decoder_unit_tb.sv]
module utf8_to_utf16_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import u8u16_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int TAIL_CYCLES = 10;
   localparam int PHASE_BYTES = 100;
   localparam int NUM_ROWS = 28;

   // marker bits folded into the shifted byte sum, per trail count
   localparam logic [31:0] MARK_SUM [6] = '{
      32'h0000_0000, 32'h0000_3080, 32'h000E_2080,
      32'h03C8_2080, 32'hFA08_2080, 32'h8208_2080
   };

   typedef enum logic {
      ROW_BYTE,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   data;
      logic         eos;
      logic         typed;
      logic [1:0]   n_units;
      logic [15:0]  unit_a;
      logic [15:0]  unit_b;
   } dir_row_type;

   // directed stimulus: code point extremes, pair boundaries, surrogates when lenient
   localparam dir_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{ROW_BYTE, 8'h00, 1'b0, 1'b1, 2'd1, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'h7F, 1'b0, 1'b1, 2'd1, 16'h007F, 16'h0000},
      '{ROW_BYTE, 8'hC2, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'h80, 1'b0, 1'b1, 2'd1, 16'h0080, 16'h0000},
      '{ROW_BYTE, 8'hDF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'hBF, 1'b0, 1'b1, 2'd1, 16'h07FF, 16'h0000},
      '{ROW_BYTE, 8'hE0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'hA0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'hEF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'hBF, 1'b0, 1'b1, 2'd1, 16'hFFFF, 16'h0000},
      '{ROW_BYTE, 8'hF0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'h90, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'hF4, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'h8F, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'hBF, 1'b0, 1'b1, 2'd2, 16'hDBFF, 16'hDFFF},
      '{ROW_CSR,  8'h00, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'hED, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'hA0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'hED, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_BYTE, 8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      '{ROW_CSR,  8'h01, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000}
   };

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_data = 1'b0;

   // decoder state as predicted
   logic [7:0]   seq_lead = '0;
   logic [2:0]   seq_need = '0;
   logic [2:0]   seq_seen = '0;
   logic [7:0]   seq_first = '0;
   logic         seq_trail_bad = 1'b0;
   logic [31:0]  seq_sum = '0;
   logic         dec_halted = 1'b0;
   logic         strict_q = 1'b1;

   rsp_word_type step_words[$];
   rsp_word_type decoded_words[$];
   logic [7:0]   seq_bytes[$];
   dir_row_type  cur_row = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int idle_cycles = 0;

   utf8_to_utf16_decoder_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] pick_byte(input int lo, input int hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   function automatic logic [2:0] lead_trail_count(input logic [7:0] b);
      if (b < 8'hC0) return 3'd0;
      if (b < 8'hE0) return 3'd1;
      if (b < 8'hF0) return 3'd2;
      if (b < 8'hF8) return 3'd3;
      if (b < 8'hFC) return 3'd4;
      return 3'd5;
   endfunction

   function automatic void add_word(input logic [15:0] unit, input status_type st);
      step_words.push_back('{code_unit: unit, status: st, last: 1'b0});
   endfunction

   // words caused by one byte, left in step_words
   function automatic void decode_byte(input logic [7:0] b, input logic eos);
      logic [2:0]  need;
      logic        done;
      logic        bad;
      logic [31:0] cp;
      step_words.delete();
      if (dec_halted) return;
      done = 1'b0;
      bad = 1'b0;
      need = 3'd0;
      // open a sequence or gather a trail byte
      if (seq_need == 3'd0) begin
         seq_lead = b;
         need = lead_trail_count(b);
         seq_seen = 3'd0;
         seq_first = 8'h00;
         seq_trail_bad = 1'b0;
         seq_sum = {24'h0, b};
         if (need == 3'd0) done = 1'b1;
         else seq_need = need;
      end else begin
         need = seq_need;
         seq_sum = (seq_sum << 6) + {24'h0, b};
         if (seq_seen == 3'd0) seq_first = b;
         else if (b < 8'h80 || b > 8'hBF) seq_trail_bad = 1'b1;
         seq_seen = seq_seen + 3'd1;
         if (seq_seen >= need) done = 1'b1;
      end
      // judge the complete sequence
      if (done) begin
         seq_need = 3'd0;
         seq_seen = 3'd0;
         bad = need > 3'd3 || (seq_lead >= 8'h80 && seq_lead < 8'hC2) || seq_lead > 8'hF4;
         if (need != 3'd0) begin
            bad = bad || seq_first < 8'h80 || seq_first > 8'hBF || seq_trail_bad
               || (seq_lead == 8'hE0 && seq_first < 8'hA0)
               || (seq_lead == 8'hF0 && seq_first < 8'h90)
               || (seq_lead == 8'hF4 && seq_first > 8'h8F);
         end
         if (!bad) begin
            cp = seq_sum - MARK_SUM[need];
            if (cp <= 32'h0000_FFFF) begin
               if (strict_q && cp >= 32'h0000_D800 && cp <= 32'h0000_DFFF) bad = 1'b1;
               else add_word(cp[15:0], STAT_UNIT);
            end else if (cp > 32'h0010_FFFF) begin
               bad = 1'b1;
            end else begin
               cp = cp - 32'h0001_0000;
               add_word(16'hD800 + {6'h00, cp[19:10]}, STAT_UNIT);
               add_word(16'hDC00 + {6'h00, cp[9:0]}, STAT_UNIT);
            end
         end
      end
      // terminal status words
      if (bad) begin
         step_words.delete();
         add_word(16'h0000, STAT_ILLEGAL);
         dec_halted = 1'b1;
      end else if (eos) begin
         add_word(16'h0000, done ? STAT_DONE : STAT_PARTIAL);
         dec_halted = 1'b1;
      end
      if (step_words.size() != 0) step_words[step_words.size()-1].last = 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input rsp_word_type want,
                                  input rsp_word_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch (%s): expected unit %h status %0d last %b, got unit %h status %0d last %b",
                  what, want.code_unit, want.status, want.last,
                  got.code_unit, got.status, got.last);
      end
   endtask

   // predict each accepted byte, then check each accepted result word
   always @(posedge clock) begin : scoreboard
      rsp_word_type want;
      if (!reset && req_valid && !req_stall) begin
         decode_byte(req_data.byte_in, req_data.end_of_stream);
         if (cur_row.typed) begin
            for (int k = 0; k < int'(cur_row.n_units); k++) begin
               decoded_words.push_back('{code_unit: (k == 0) ? cur_row.unit_a : cur_row.unit_b,
                                         status: STAT_UNIT,
                                         last: 1'(k == int'(cur_row.n_units) - 1)});
            end
         end else begin
            foreach (step_words[k]) decoded_words.push_back(step_words[k]);
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_words.size() == 0) begin
            report_mismatch("unexpected word", '0, rsp_data);
         end else begin
            want = decoded_words.pop_front();
            if (want.code_unit !== rsp_data.code_unit || want.status !== rsp_data.status
                || want.last !== rsp_data.last) begin
               report_mismatch("word differs", want, rsp_data);
            end
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // one byte word, with random gaps in front
   task automatic send_byte(input dir_row_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      cur_row = r;
      req_valid <= 1'b1;
      req_data <= '{byte_in: r.data, end_of_stream: r.eos};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_seq_bytes(input logic eos_on_last);
      foreach (seq_bytes[k]) begin
         send_byte('{ROW_BYTE, seq_bytes[k], eos_on_last && (k == seq_bytes.size() - 1),
                     1'b0, 2'd0, 16'h0000, 16'h0000});
      end
   endtask

   // hold the sender until every predicted word is out
   task automatic drain_results();
      req_valid <= 1'b0;
      while (decoded_words.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_strict(input logic v);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      strict_q = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // well-formed sequence of len bytes; no surrogate while strict
   function automatic void build_legal_seq(input int len);
      logic [7:0] lead;
      logic [7:0] t1;
      seq_bytes.delete();
      case (len)
         1: seq_bytes.push_back(pick_byte(8'h00, 8'h7F));
         2: begin
            seq_bytes.push_back(pick_byte(8'hC2, 8'hDF));
            seq_bytes.push_back(pick_byte(8'h80, 8'hBF));
         end
         3: begin
            lead = pick_byte(8'hE0, 8'hEF);
            if (lead == 8'hE0) t1 = pick_byte(8'hA0, 8'hBF);
            else if (lead == 8'hED && strict_q) t1 = pick_byte(8'h80, 8'h9F);
            else t1 = pick_byte(8'h80, 8'hBF);
            seq_bytes.push_back(lead);
            seq_bytes.push_back(t1);
            seq_bytes.push_back(pick_byte(8'h80, 8'hBF));
         end
         default: begin
            lead = pick_byte(8'hF0, 8'hF4);
            if (lead == 8'hF0) t1 = pick_byte(8'h90, 8'hBF);
            else if (lead == 8'hF4) t1 = pick_byte(8'h80, 8'h8F);
            else t1 = pick_byte(8'h80, 8'hBF);
            seq_bytes.push_back(lead);
            seq_bytes.push_back(t1);
            seq_bytes.push_back(pick_byte(8'h80, 8'hBF));
            seq_bytes.push_back(pick_byte(8'h80, 8'hBF));
         end
      endcase
   endfunction

   task automatic run_phase(input int snd, input int rcv, input logic strict_v);
      int sent;
      int pick;
      write_strict(strict_v);
      send_idle_pct = snd;
      recv_stall_pct = rcv;
      sent = 0;
      while (sent < PHASE_BYTES) begin
         pick = $urandom_range(99);
         build_legal_seq(pick < 30 ? 1 : pick < 55 ? 2 : pick < 80 ? 3 : 4);
         send_seq_bytes(1'b0);
         sent += seq_bytes.size();
         if ($urandom_range(29) == 0) drain_results();
      end
   endtask

   // the block halts for good on the first bad sequence or stream end,
   // so one terminating case is picked per run
   task automatic finish_stream();
      int         pick;
      int         keep;
      logic       eos;
      logic [7:0] lead;
      pick = $urandom_range(11);
      eos = 1'($urandom_range(1));
      seq_bytes.delete();
      case (pick)
         // stray continuation byte as lead
         0: seq_bytes.push_back(pick_byte(8'h80, 8'hBF));
         // overlong two-byte lead
         1: begin
            seq_bytes.push_back(pick_byte(8'hC0, 8'hC1));
            seq_bytes.push_back(pick_byte(8'h80, 8'hBF));
         end
         // four-byte lead past the code space
         2: begin
            seq_bytes.push_back(pick_byte(8'hF5, 8'hF7));
            repeat (3) seq_bytes.push_back(pick_byte(8'h80, 8'hBF));
         end
         // five- and six-byte leads gather any bytes, then fail
         3: begin
            lead = pick_byte(8'hF8, 8'hFF);
            seq_bytes.push_back(lead);
            repeat (int'(lead_trail_count(lead))) seq_bytes.push_back(pick_byte(8'h00, 8'hFF));
         end
         // first trail byte below the continuation range
         4: begin
            build_legal_seq(int'($urandom_range(4, 2)));
            seq_bytes[1] = pick_byte(8'h00, 8'h7F);
         end
         // later trail byte outside the continuation range
         5: begin
            build_legal_seq(int'($urandom_range(4, 3)));
            seq_bytes[seq_bytes.size()-1] = $urandom_range(1) ? pick_byte(8'h00, 8'h7F)
                                                               : pick_byte(8'hC0, 8'hFF);
         end
         // overlong three-byte form
         6: begin
            seq_bytes.push_back(8'hE0);
            seq_bytes.push_back(pick_byte(8'h80, 8'h9F));
            seq_bytes.push_back(pick_byte(8'h80, 8'hBF));
         end
         // overlong four-byte form
         7: begin
            seq_bytes.push_back(8'hF0);
            seq_bytes.push_back(pick_byte(8'h80, 8'h8F));
            repeat (2) seq_bytes.push_back(pick_byte(8'h80, 8'hBF));
         end
         // above the last code point
         8: begin
            seq_bytes.push_back(8'hF4);
            seq_bytes.push_back(pick_byte(8'h90, 8'hBF));
            repeat (2) seq_bytes.push_back(pick_byte(8'h80, 8'hBF));
         end
         // surrogate code point while strict
         9: begin
            write_strict(1'b1);
            seq_bytes.push_back(8'hED);
            seq_bytes.push_back(pick_byte(8'hA0, 8'hBF));
            seq_bytes.push_back(pick_byte(8'h80, 8'hBF));
         end
         // stream ends in mid-sequence
         10: begin
            build_legal_seq(int'($urandom_range(4, 2)));
            keep = int'($urandom_range(seq_bytes.size() - 1, 1));
            while (seq_bytes.size() > keep) void'(seq_bytes.pop_back());
            eos = 1'b1;
         end
         // stream ends right after a complete sequence
         default: begin
            build_legal_seq(int'($urandom_range(4, 1)));
            eos = 1'b1;
         end
      endcase
      send_seq_bytes(eos);
      // halted: further bytes are dropped without a word
      repeat (3) begin
         send_byte('{ROW_BYTE, pick_byte(8'h00, 8'hFF), 1'($urandom_range(1)),
                     1'b0, 2'd0, 16'h0000, 16'h0000});
      end
   endtask

   // stall watchdog: cycles with no word moving on any channel
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("utf8_to_utf16_decoder_unit_tb: FAIL");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      send_idle_pct = 37;
      recv_stall_pct = 84;
      for (int i = 0; i < NUM_ROWS; i++) begin
         if (DIRECTED_ROWS[i].kind == ROW_CSR) write_strict(DIRECTED_ROWS[i].data[0]);
         else send_byte(DIRECTED_ROWS[i]);
      end

      // random well-formed traffic under three idle profiles
      run_phase(37, 84, 1'b0);
      run_phase(84, 37, 1'b1);
      run_phase(0, 0, 1'b0);
      finish_stream();

      req_valid <= 1'b0;
      while (decoded_words.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && decoded_words.size() == 0)
         $display("utf8_to_utf16_decoder_unit_tb: PASS");
      else
         $display("utf8_to_utf16_decoder_unit_tb: FAIL");
      $finish;
   end

endmodule
